// ===== hw/rtl/u16u8_pkg.sv =====
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
`default_nettype none

package u16u8_pkg;

    // Reset value of the length limit register
    localparam logic [15:0] LIMIT_RESET = 16'd4096;

    // Default number of jobs the queue between front and back holds
    localparam int QUEUE_DEPTH_DEF = 4;

    // Result status codes
    localparam logic [1:0] ST_DATA   = 2'd0;
    localparam logic [1:0] ST_OK     = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    // Surrogate ranges
    localparam logic [15:0] HI_SURR_MIN = 16'hD800;
    localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    // UTF-8 size thresholds, lead prefixes and continuation marks
    localparam logic [20:0] LIM_1BYTE   = 21'h80;
    localparam logic [20:0] LIM_2BYTE   = 21'h800;
    localparam logic [20:0] LIM_3BYTE   = 21'h10000;
    localparam logic [7:0]  PFX_2BYTE   = 8'hC0;
    localparam logic [7:0]  PFX_3BYTE   = 8'hE0;
    localparam logic [7:0]  PFX_4BYTE   = 8'hF0;
    localparam logic [7:0]  CONT_MARK   = 8'h80;
    localparam logic [5:0]  CONT_MASK   = 6'h3F;

    // One unit of work handed from the front to the back.
    //   rej: emit a single reject result
    //   nb:  number of UTF-8 data bytes of cp (0 when none)
    //   fin: append a terminator after the data bytes
    typedef struct packed {
        logic        rej;
        logic        fin;
        logic [2:0]  nb;
        logic [20:0] cp;
    } t_job;

endpackage

`default_nettype wire

// ===== hw/rtl/u16u8_front.sv =====
// Front end: accepts code units, pairs surrogates, checks limits, issues jobs.
`default_nettype none

module u16u8_front
    import u16u8_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_length_limit_we,
    input  wire logic [15:0] i_length_limit,
    input  wire logic        i_accept,
    input  wire logic [15:0] i_code_unit,
    input  wire logic        i_is_last,
    input  wire logic        i_is_empty,
    output logic             o_push,
    output t_job             o_job
);

    logic [15:0] r_limit;
    logic [15:0] r_uc, n_uc;
    logic [15:0] r_bc, n_bc;
    logic [9:0]  r_hs, n_hs;
    logic        r_hp, n_hp;
    logic        r_rej, n_rej;

    logic        w_is_hi;
    logic        w_is_lo;
    logic [20:0] w_cp;
    logic [2:0]  w_nb;
    logic [16:0] w_uc_inc;
    logic [16:0] w_bc_sum;
    logic        w_unit_ovf;
    logic        w_byte_ovf;
    logic        w_bad;
    logic        w_hold;

    assign w_is_hi = (i_code_unit >= HI_SURR_MIN) && (i_code_unit <= HI_SURR_MAX);
    assign w_is_lo = (i_code_unit >= LO_SURR_MIN) && (i_code_unit <= LO_SURR_MAX);

    // Pending high half joins the low half into a supplementary code point
    assign w_cp = r_hp ? ({1'b0, r_hs, i_code_unit[9:0]} + SUPP_BASE)
                       : {5'b0, i_code_unit};

    assign w_nb = (w_cp < LIM_1BYTE) ? 3'd1 :
                  (w_cp < LIM_2BYTE) ? 3'd2 :
                  (w_cp < LIM_3BYTE) ? 3'd3 : 3'd4;

    assign w_uc_inc   = {1'b0, r_uc} + 17'd1;
    assign w_bc_sum   = {1'b0, r_bc} + {14'b0, w_nb};
    assign w_unit_ovf = w_uc_inc >= {1'b0, r_limit};
    assign w_byte_ovf = w_bc_sum >= {1'b0, r_limit};

    assign w_bad = w_unit_ovf ||
                   (r_hp ? (!w_is_lo || w_byte_ovf)
                         : (w_is_lo || (w_is_hi ? i_is_last
                                                : ((w_cp == '0) || w_byte_ovf))));
    assign w_hold = !r_hp && w_is_hi && !i_is_last && !w_unit_ovf;

    always_comb begin
        n_uc   = r_uc;
        n_bc   = r_bc;
        n_hs   = r_hs;
        n_hp   = r_hp;
        n_rej  = r_rej;
        o_push = 1'b0;
        o_job  = '0;
        if (i_accept) begin
            if (r_rej) begin
                // drop units of a rejected string until its last one
                if (i_is_last) begin
                    n_uc  = '0;
                    n_bc  = '0;
                    n_hs  = '0;
                    n_hp  = 1'b0;
                    n_rej = 1'b0;
                end
            end else if (i_is_empty) begin
                if (i_is_last) begin
                    o_push    = 1'b1;
                    o_job.rej = (r_uc == '0) || r_hp;
                    o_job.fin = !((r_uc == '0) || r_hp);
                    n_uc      = '0;
                    n_bc      = '0;
                    n_hs      = '0;
                    n_hp      = 1'b0;
                end
            end else if (w_bad) begin
                o_push    = 1'b1;
                o_job.rej = 1'b1;
                if (i_is_last) begin
                    n_uc = '0;
                    n_bc = '0;
                    n_hs = '0;
                    n_hp = 1'b0;
                end else begin
                    n_rej = 1'b1;
                end
            end else if (w_hold) begin
                // park the high half until its partner arrives
                n_uc = w_uc_inc[15:0];
                n_hp = 1'b1;
                n_hs = i_code_unit[9:0];
            end else begin
                o_push    = 1'b1;
                o_job.nb  = w_nb;
                o_job.cp  = w_cp;
                o_job.fin = i_is_last;
                if (i_is_last) begin
                    n_uc = '0;
                    n_bc = '0;
                end else begin
                    n_uc = w_uc_inc[15:0];
                    n_bc = w_bc_sum[15:0];
                end
                n_hs = '0;
                n_hp = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_uc    <= '0;
            r_bc    <= '0;
            r_hs    <= '0;
            r_hp    <= 1'b0;
            r_rej   <= 1'b0;
        end else begin
            if (i_length_limit_we) begin
                r_limit <= i_length_limit;
            end
            r_uc  <= n_uc;
            r_bc  <= n_bc;
            r_hs  <= n_hs;
            r_hp  <= n_hp;
            r_rej <= n_rej;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/u16u8_queue.sv =====
// Small job queue between the front end and the byte emitter.
`default_nettype none

module u16u8_queue
    import u16u8_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    output logic      o_valid,
    output t_job      o_job,
    input  wire logic i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = r_cnt == FULL_CNT;
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/u16u8_back.sv =====
// Back end: expands each job into result words through an output register.
`default_nettype none

module u16u8_back
    import u16u8_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  wire t_job i_job,
    output logic      o_pop,
    output logic       o_valid,
    input  wire logic  i_stall,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic       o_end_of_run
);

    logic [2:0] r_idx;
    logic       r_ov;
    logic [7:0] r_byte;
    logic [1:0] r_stat;
    logic       r_eor;

    logic [2:0] w_total;
    logic       w_last_step;
    logic       w_load;
    logic [2:0] w_shift;
    logic [7:0] w_lead;
    logic [7:0] w_cont;
    logic [7:0] w_byte;
    logic [1:0] w_stat;

    assign w_total     = i_job.rej ? 3'd1 : (i_job.nb + {2'b0, i_job.fin});
    assign w_last_step = r_idx == (w_total - 3'd1);
    assign w_load      = i_job_valid && (!r_ov || !i_stall);
    assign o_pop       = w_load && w_last_step;
    assign w_shift     = i_job.nb - 3'd1 - r_idx;

    always_comb begin
        case (i_job.nb)
            3'd1:    w_lead = {1'b0, i_job.cp[6:0]};
            3'd2:    w_lead = PFX_2BYTE | {3'b0, i_job.cp[10:6]};
            3'd3:    w_lead = PFX_3BYTE | {4'b0, i_job.cp[15:12]};
            3'd4:    w_lead = PFX_4BYTE | {5'b0, i_job.cp[20:18]};
            default: w_lead = '0;
        endcase
    end

    always_comb begin
        case (w_shift)
            3'd0:    w_cont = CONT_MARK | {2'b0, i_job.cp[5:0] & CONT_MASK};
            3'd1:    w_cont = CONT_MARK | {2'b0, i_job.cp[11:6] & CONT_MASK};
            3'd2:    w_cont = CONT_MARK | {2'b0, i_job.cp[17:12] & CONT_MASK};
            default: w_cont = '0;
        endcase
    end

    always_comb begin
        if (i_job.rej) begin
            w_byte = '0;
            w_stat = ST_REJECT;
        end else if (r_idx < i_job.nb) begin
            w_byte = (r_idx == '0) ? w_lead : w_cont;
            w_stat = ST_DATA;
        end else begin
            w_byte = '0;
            w_stat = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= w_byte;
            r_stat <= w_stat;
            r_eor  <= w_last_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_idx <= '0;
        end else begin
            if (w_load) begin
                r_ov  <= 1'b1;
                r_idx <= w_last_step ? '0 : r_idx + 3'd1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid      = r_ov;
    assign o_out_byte   = r_byte;
    assign o_status     = r_stat;
    assign o_end_of_run = r_eor;

endmodule

`default_nettype wire

// ===== hw/rtl/utf16_to_utf8_bounded_unit.sv =====
// Top level of the bounded UTF-16 to UTF-8 string transcoder.
// The block takes a string one UTF-16 code unit per input word and returns
// its UTF-8 encoding one byte per output word. Surrogate pairs are joined
// into supplementary characters. When the last word of a string arrives, a
// terminator word (byte 0, status ok) follows its data bytes; a bad string
// (empty, too many units, lone or unpaired surrogate, code point zero, or
// output plus terminator that would exceed the length limit) gets a single
// reject word and its remaining words up to the last are dropped. Bytes sent
// before a reject are not taken back: discard them on reject. end_of_run
// marks the final output word caused by one input word. Timing: the front
// end takes one input word per cycle as long as its job queue
// (QUEUE_DEPTH entries) has room; the byte emitter sends one output word per
// cycle while the output is not stalled, and an input word produces one to
// five output words (a one-byte character one word, a supplementary character
// with its terminator five). Sustained throughput is thus set by the
// byte-wide output register. Words that produce nothing (a high surrogate,
// a dropped word) push no job into the queue.
// Write length_limit only while no string is in flight.
`default_nettype none

module utf16_to_utf8_bounded_unit
    import u16u8_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // length limit register
    input  wire logic        i_length_limit_we,
    input  wire logic [15:0] i_length_limit,
    // input words
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_code_unit,
    input  wire logic        i_is_last,
    input  wire logic        i_is_empty,
    // output words
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte,
    output logic [1:0]       o_status,
    output logic             o_end_of_run
);

    logic w_accept;
    logic w_push;
    t_job w_push_job;
    logic w_full;
    logic w_job_valid;
    t_job w_job;
    logic w_pop;

    // Hold off input only while the queue is full
    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    u16u8_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_length_limit_we (i_length_limit_we),
        .i_length_limit    (i_length_limit),
        .i_accept          (w_accept),
        .i_code_unit       (i_code_unit),
        .i_is_last         (i_is_last),
        .i_is_empty        (i_is_empty),
        .o_push            (w_push),
        .o_job             (w_push_job)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .o_valid (w_job_valid),
        .o_job   (w_job),
        .i_pop   (w_pop)
    );

    u16u8_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_job_valid),
        .i_job        (w_job),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_status     (o_status),
        .o_end_of_run (o_end_of_run)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/u16u8_checker.sv =====
// Port-level checks of the transcoder, bound to the top level.
`default_nettype none

module u16u8_checker
    import u16u8_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [7:0]  o_out_byte,
    input wire logic [1:0]  o_status,
    input wire logic        o_end_of_run
);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) &&
                               $stable(o_status) && $stable(o_end_of_run))
        else $error("output word changed while stalled");

    // Terminator and reject always close the run of their input word
    a_close_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_OK || o_status == ST_REJECT) |-> o_end_of_run)
        else $error("terminator or reject without end_of_run");

    // Terminator and reject carry a zero byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_OK || o_status == ST_REJECT) |-> o_out_byte == 8'd0)
        else $error("terminator or reject with nonzero byte");

    // A data byte is never zero: code point zero is rejected
    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_DATA |-> o_out_byte != 8'd0)
        else $error("zero data byte");

endmodule

bind utf16_to_utf8_bounded_unit u16u8_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_out_byte   (o_out_byte),
    .o_status     (o_status),
    .o_end_of_run (o_end_of_run)
);

`default_nettype wire

// ===== tb/utf16_to_utf8_bounded_checker.sv =====
`timescale 1ns / 1ps
// Output checker for the UTF-16 to UTF-8 transcoder: predicts each output word and compares.
`default_nettype none

module utf16_to_utf8_bounded_checker
    import u16u8_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_length_limit_we,
    input  wire logic [15:0] i_length_limit,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [15:0] i_code_unit,
    input  wire logic        i_is_last,
    input  wire logic        i_is_empty,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [7:0]  i_out_byte,
    input  wire logic [1:0]  i_status,
    input  wire logic        i_end_of_run,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic       eor;
    } t_utf8_word;

    t_utf8_word  utf8_expected_q[$];
    t_utf8_word  want;
    logic [15:0] limit;
    int          unit_cnt;
    int          byte_cnt;
    logic [9:0]  hi_bits;
    logic        hi_pending;
    logic        str_dropped;
    int          fails = 0;

    function automatic void clear_string();
        unit_cnt    = 0;
        byte_cnt    = 0;
        hi_bits     = '0;
        hi_pending  = 1'b0;
        str_dropped = 1'b0;
    endfunction

    // Work out the output words one input word causes and queue them.
    function automatic void transcode_word(input logic [15:0] cu, input logic last,
                                           input logic empty);
        logic [7:0]  seq_data[5];
        logic [1:0]  seq_stat[5];
        t_utf8_word  w;
        logic [20:0] cp;
        logic [7:0]  prefix;
        logic        rej;
        int          nb;
        int          n;
        int          r;
        n   = 0;
        nb  = 0;
        rej = 1'b0;
        cp  = '0;
        if (str_dropped) begin
            if (last)
                clear_string();
            return;
        end
        if (empty) begin
            if (!last)
                return;
            rej = (unit_cnt == 0) || hi_pending;
        end else if (unit_cnt + 1 >= int'(limit)) begin
            rej = 1'b1;
        end else begin
            unit_cnt++;
            if (hi_pending) begin
                if (cu < LO_SURR_MIN || cu > LO_SURR_MAX) begin
                    rej = 1'b1;
                end else begin
                    cp = SUPP_BASE + {1'b0, hi_bits, 10'b0} + 21'(cu - LO_SURR_MIN);
                    hi_pending = 1'b0;
                    hi_bits    = '0;
                end
            end else if (cu >= HI_SURR_MIN && cu <= HI_SURR_MAX) begin
                if (last) begin
                    rej = 1'b1;
                end else begin
                    // hold the high half until its partner arrives
                    hi_pending = 1'b1;
                    hi_bits    = cu[9:0];
                    return;
                end
            end else if (cu >= LO_SURR_MIN && cu <= LO_SURR_MAX) begin
                rej = 1'b1;
            end else begin
                cp = 21'(cu);
            end
            if (!rej && cp == '0)
                rej = 1'b1;
            if (!rej) begin
                nb = (cp < LIM_1BYTE) ? 1 : (cp < LIM_2BYTE) ? 2 : (cp < LIM_3BYTE) ? 3 : 4;
                if (byte_cnt + nb >= int'(limit))
                    rej = 1'b1;
                else
                    byte_cnt += nb;
            end
        end

        if (rej) begin
            seq_data[0] = 8'h00;
            seq_stat[0] = ST_REJECT;
            n = 1;
            if (last)
                clear_string();
            else
                str_dropped = 1'b1;
        end else begin
            if (nb == 1) begin
                seq_data[n] = cp[7:0];
                seq_stat[n] = ST_DATA;
                n++;
            end else if (nb > 1) begin
                prefix = (nb == 2) ? PFX_2BYTE : (nb == 3) ? PFX_3BYTE : PFX_4BYTE;
                seq_data[n] = prefix | 8'(cp >> (6 * (nb - 1)));
                seq_stat[n] = ST_DATA;
                n++;
                for (r = nb - 2; r >= 0; r--) begin
                    seq_data[n] = CONT_MARK | {2'b00, 6'(cp >> (6 * r)) & CONT_MASK};
                    seq_stat[n] = ST_DATA;
                    n++;
                end
            end
            if (last) begin
                seq_data[n] = 8'h00;
                seq_stat[n] = ST_OK;
                n++;
                clear_string();
            end
        end

        for (r = 0; r < n; r++) begin
            w.data   = seq_data[r];
            w.status = seq_stat[r];
            w.eor    = (r == n - 1);
            utf8_expected_q = {utf8_expected_q, w};
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limit = LIMIT_RESET;
            clear_string();
            utf8_expected_q.delete();
        end else begin
            // compare first: a word leaving now was caused by an earlier input
            if (i_out_valid && !i_out_stall) begin
                if (utf8_expected_q.size() == 0) begin
                    $error("unexpected output word: out_byte %02h status %0d end_of_run %0b",
                           i_out_byte, i_status, i_end_of_run);
                    fails++;
                end else begin
                    want = utf8_expected_q.pop_front();
                    if (i_out_byte !== want.data) begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.data, i_out_byte);
                        fails++;
                    end
                    if (i_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_status);
                        fails++;
                    end
                    if (i_end_of_run !== want.eor) begin
                        $error("end_of_run mismatch: expected %0b, actual %0b",
                               want.eor, i_end_of_run);
                        fails++;
                    end
                end
            end
            if (i_length_limit_we)
                limit = i_length_limit;
            if (i_in_valid && !i_in_stall)
                transcode_word(i_code_unit, i_is_last, i_is_empty);
        end
        o_fail_count <= fails;
        o_pending    <= utf8_expected_q.size();
    end

endmodule

`default_nettype wire

// ===== tb/utf16_to_utf8_bounded_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the UTF-16 to UTF-8 transcoder: stimulus, handshake idling and verdict.
`default_nettype none

module utf16_to_utf8_bounded_unit_tb;
    import u16u8_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 8;
    // Cycles to let the front end empty its queue after the last expected word;
    // words that cause nothing (high halves, dropped words) may still be in flight.
    localparam int DRAIN_CYCLES   = 40;
    // Cycles in a row without any handshake before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_length_limit_we = 1'b0;
    logic [15:0] i_length_limit    = '0;
    logic        i_valid           = 1'b0;
    logic        o_stall;
    logic [15:0] i_code_unit       = '0;
    logic        i_is_last         = 1'b0;
    logic        i_is_empty        = 1'b0;
    logic        o_valid;
    logic        i_stall           = 1'b0;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_status;
    logic        o_end_of_run;

    int   fail_count;
    int   words_pending;
    int   items_sent  = 0;
    int   idle_cycles = 0;
    int   rx_wait     = 0;
    logic out_took    = 1'b0;
    // Set per string: drop all idling on both sides to get back-to-back stretches.
    logic no_idle     = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    utf16_to_utf8_bounded_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_length_limit_we (i_length_limit_we),
        .i_length_limit    (i_length_limit),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_code_unit       (i_code_unit),
        .i_is_last         (i_is_last),
        .i_is_empty        (i_is_empty),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_out_byte        (o_out_byte),
        .o_status          (o_status),
        .o_end_of_run      (o_end_of_run)
    );

    utf16_to_utf8_bounded_checker i_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_length_limit_we (i_length_limit_we),
        .i_length_limit    (i_length_limit),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_code_unit       (i_code_unit),
        .i_is_last         (i_is_last),
        .i_is_empty        (i_is_empty),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_out_byte        (o_out_byte),
        .i_status          (o_status),
        .i_end_of_run      (o_end_of_run),
        .o_fail_count      (fail_count),
        .o_pending         (words_pending)
    );

    // Receiver: after each accepted output word, draw how many cycles to stall
    // before taking the next one. Note the take at the rising edge, act on the
    // falling edge so stall only changes away from the sampling edge.
    always @(posedge i_clk)
        out_took <= o_valid && !i_stall;

    always @(negedge i_clk) begin
        if (out_took)
            rx_wait = no_idle ? 0 : $urandom_range(0, 4);
        if (rx_wait > 0) begin
            i_stall <= 1'b1;
            rx_wait--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog: reset the count on any handshake, give up when it runs out.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("utf16_to_utf8_bounded_unit_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Send one input word. Entered and left on a falling edge. Valid stays high
    // after the handshake so a following word with no gap is driven without
    // dropping valid in between; the caller lowers it when the stream pauses.
    task automatic send_word(input logic [15:0] cu, input logic last, input logic empty);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_code_unit <= cu;
        i_is_last   <= last;
        i_is_empty  <= empty;
        // hold the payload until the block takes it
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        @(negedge i_clk);
        if (!(empty && !last))
            items_sent++;
    endtask

    // Wait until every predicted word is out and any silent work has drained.
    task automatic settle();
        i_valid <= 1'b0;
        while (words_pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] lim);
        i_length_limit_we <= 1'b1;
        i_length_limit    <= lim;
        @(negedge i_clk);
        i_length_limit_we <= 1'b0;
    endtask

    // One random string: mostly well-formed characters of every UTF-8 size,
    // with occasional zero units, lone or unpaired surrogates, empty items in
    // the middle, an empty item as terminator, and a few empty strings.
    task automatic send_random_string(input int max_chars);
        int          nchars;
        int          k;
        int          pick;
        logic        end_empty;
        logic        last_here;
        logic [15:0] cu;
        nchars    = $urandom_range(1, max_chars);
        end_empty = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 19) == 0) begin
            send_word(16'($urandom), 1'b1, 1'b1);
            return;
        end
        for (k = 0; k < nchars; k++) begin
            last_here = (k == nchars - 1) && !end_empty;
            pick      = $urandom_range(0, 99);
            if (pick < 28) begin
                send_word(16'($urandom_range(1, 'h7F)), last_here, 1'b0);
            end else if (pick < 48) begin
                send_word(16'($urandom_range('h80, 'h7FF)), last_here, 1'b0);
            end else if (pick < 68) begin
                // skip over the surrogate block
                cu = 16'($urandom_range('h800, 'hF7FF));
                if (cu >= HI_SURR_MIN)
                    cu = cu + 16'h0800;
                send_word(cu, last_here, 1'b0);
            end else if (pick < 87) begin
                send_word(HI_SURR_MIN | 16'($urandom_range(0, 'h3FF)), 1'b0, 1'b0);
                send_word(LO_SURR_MIN | 16'($urandom_range(0, 'h3FF)), last_here, 1'b0);
            end else if (pick < 90) begin
                send_word(16'h0000, last_here, 1'b0);
            end else if (pick < 92) begin
                send_word(16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX)), last_here, 1'b0);
            end else if (pick < 94) begin
                // high half followed by whatever comes next
                send_word(16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX)), last_here, 1'b0);
            end else if (pick < 97) begin
                send_word(16'($urandom), 1'b0, 1'b1);
                send_word(16'($urandom_range(1, 'h7F)), last_here, 1'b0);
            end else begin
                send_word(16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX)), 1'b0, 1'b0);
                if (last_here)
                    send_word(16'($urandom), 1'b1, 1'b1);
            end
        end
        if (end_empty)
            send_word(16'($urandom), 1'b1, 1'b1);
    endtask

    // Write a new limit while idle, then run random strings until enough words went in.
    task automatic run_phase(input logic [15:0] lim, input int n_items, input int max_chars);
        int target;
        settle();
        write_limit(lim);
        target = items_sent + n_items;
        while (items_sent < target) begin
            no_idle = ($urandom_range(0, 3) == 0);
            send_random_string(max_chars);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed strings at the reset limit.
        send_word(16'h0041, 1'b1, 1'b0);
        // size boundaries of the encoding, top of the BMP
        send_word(16'h007F, 1'b0, 1'b0);
        send_word(16'h0080, 1'b0, 1'b0);
        send_word(16'h07FF, 1'b0, 1'b0);
        send_word(16'h0800, 1'b0, 1'b0);
        send_word(16'hFFFF, 1'b1, 1'b0);
        // lowest and highest supplementary characters
        send_word(HI_SURR_MIN, 1'b0, 1'b0);
        send_word(LO_SURR_MIN, 1'b0, 1'b0);
        send_word(HI_SURR_MAX, 1'b0, 1'b0);
        send_word(LO_SURR_MAX, 1'b1, 1'b0);
        // empty string
        send_word(16'h0000, 1'b1, 1'b1);
        // empty item mid-string is ignored, empty last item ends the string
        send_word(16'h0041, 1'b0, 1'b0);
        send_word(16'hFFFF, 1'b0, 1'b1);
        send_word(16'h0000, 1'b1, 1'b1);
        // lone low surrogate, then the rest of the string is dropped
        send_word(LO_SURR_MIN, 1'b0, 1'b0);
        send_word(16'h0041, 1'b0, 1'b0);
        send_word(16'h0042, 1'b1, 1'b0);
        // high surrogate as the last unit
        send_word(HI_SURR_MIN, 1'b1, 1'b0);
        // high surrogate not followed by a low one
        send_word(HI_SURR_MIN, 1'b0, 1'b0);
        send_word(16'h0041, 1'b1, 1'b0);
        // code point zero
        send_word(16'h0000, 1'b1, 1'b0);
        // empty last item while a high half waits
        send_word(16'hD801, 1'b0, 1'b0);
        send_word(16'h0000, 1'b1, 1'b1);

        // Random part across limits: lowest legal, small enough to hit the unit
        // and byte bounds often, the top value, and the tiny ones that reject all.
        run_phase(16'd2,     25, 4);
        run_phase(16'd5,     30, 6);
        run_phase(16'd12,    30, 8);
        run_phase(16'hFFFF,  30, 8);
        run_phase(16'd40,    25, 8);
        run_phase(16'd1,      5, 2);
        run_phase(16'd0,      5, 2);
        run_phase(16'd300,   15, 8);

        settle();
        if (fail_count == 0 && words_pending == 0) begin
            $display("utf16_to_utf8_bounded_unit_tb OK");
        end else begin
            $display("utf16_to_utf8_bounded_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/u16u8_pkg.sv
hw/rtl/u16u8_front.sv
hw/rtl/u16u8_queue.sv
hw/rtl/u16u8_back.sv
hw/rtl/utf16_to_utf8_bounded_unit.sv
hw/rtl/u16u8_checker.sv
tb/utf16_to_utf8_bounded_checker.sv
tb/utf16_to_utf8_bounded_unit_tb.sv
